>>> rtl/pll_output_rate_calculator_core_macros.svh
// Assertion macros used by the RTL
`ifndef PLL_OUTPUT_RATE_CALCULATOR_CORE_MACROS_SVH
`define PLL_OUTPUT_RATE_CALCULATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PORC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`define PORC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("impl");
`define PORC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("next");
`else
`define PORC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define PORC_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define PORC_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/porc_pkg.sv
package porc_pkg;

    localparam int RATE_W = 44;
    localparam int DVS_W  = 28;
    localparam int NUM_CELLS = RATE_W;
    localparam logic [31:0] HALF_SCALE = 32'h8000_0000;

    localparam logic [1:0] MODE_INT    = 2'd0;
    localparam logic [1:0] MODE_FRAC   = 2'd1;
    localparam logic [1:0] MODE_BYPASS = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    localparam logic [2:0] REG_HAS_PRE    = 3'd0;
    localparam logic [2:0] REG_HAS_POST   = 3'd1;
    localparam logic [2:0] REG_PRE_CODED  = 3'd2;
    localparam logic [2:0] REG_POST_CODED = 3'd3;
    localparam logic [2:0] REG_SIGNED_FR  = 3'd4;
    localparam logic [2:0] REG_FIXED_DIV  = 3'd5;

    typedef struct packed {
        logic       has_pre;
        logic       has_post;
        logic       pre_coded;
        logic       post_coded;
        logic       signed_fr;
        logic [7:0] fixed_div;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        mode;
        logic              fault;
        logic              kill;
        logic [DVS_W-1:0]  rem;
        logic [RATE_W-1:0] sh;
        logic [DVS_W-1:0]  dvs;
    } cell_t;

    function automatic logic [7:0] decode_scaler(logic present, logic coded, logic [7:0] w);
        logic [7:0] r;
        if (!present)
            r = 8'd1;
        else if (coded)
            r = {4'd0, w[7:4]} + 8'd1;
        else
            r = w;
        return r;
    endfunction

endpackage

>>> rtl/porc_front.sv
module porc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        control_word,
    input  logic [31:0]        fraction_word,
    input  logic [7:0]         pre_scaler_word,
    input  logic [7:0]         post_scaler_word,
    input  logic [31:0]        reference_rate,
    input  porc_pkg::cfg_t     cfg,
    output porc_pkg::cell_t    head
);

    // stage 1
    logic        v1_reg, down1_reg, byp1_reg, frac1_reg, neg1_reg;
    logic [31:0] ref1_reg;
    logic [63:0] pf1_reg;
    logic [39:0] ri1_reg;
    logic [4:0]  sdiv1_reg;
    logic [15:0] pp1_reg;
    logic [12:0] sf1_reg;
    // stage 2
    logic        v2_reg, byp2_reg, neg2_reg, kill2_reg, fault2_reg;
    logic [1:0]  mode2_reg;
    logic [31:0] ref2_reg;
    logic [36:0] term2_reg;
    logic [43:0] intg2_reg;
    logic [27:0] dvs2_reg;
    // stage 3
    logic        v3_reg, kill3_reg, fault3_reg;
    logic [1:0]  mode3_reg;
    logic [43:0] dvd3_reg;
    logic [27:0] dvs3_reg;

    logic [7:0]  pre, post;
    logic [31:0] fsel;
    logic        neg;
    logic [68:0] pf_s;
    logic [28:0] dvs_full;
    logic [27:0] dvs_next;

    always_comb
    begin
        pre  = porc_pkg::decode_scaler(cfg.has_pre, cfg.pre_coded, pre_scaler_word);
        post = porc_pkg::decode_scaler(cfg.has_post, cfg.post_coded, post_scaler_word);
        neg  = 1'b0;
        if (!control_word[3])
            fsel = '0;
        else if (!cfg.signed_fr)
            fsel = fraction_word;
        else if (fraction_word[31])
        begin
            fsel = porc_pkg::HALF_SCALE - {1'b0, fraction_word[30:0]};
            neg  = 1'b1;
        end
        else
            fsel = {1'b0, fraction_word[30:0]};
        pf_s     = {5'd0, pf1_reg} * {64'd0, sdiv1_reg};
        dvs_full = {13'd0, pp1_reg} * {16'd0, sf1_reg};
        dvs_next = byp1_reg ? {12'd0, pp1_reg} : dvs_full[27:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            down1_reg <= control_word[5] | control_word[6];
            byp1_reg  <= control_word[2] | control_word[21];
            frac1_reg <= control_word[3];
            neg1_reg  <= neg;
            ref1_reg  <= reference_rate;
            pf1_reg   <= {32'd0, reference_rate} * {32'd0, fsel};
            ri1_reg   <= {8'd0, reference_rate} * ({33'd0, control_word[30:24]} + 40'd1);
            sdiv1_reg <= {1'b0, control_word[15:12]} + 5'd1;
            pp1_reg   <= {8'd0, pre} * {8'd0, post};
            sf1_reg   <= ({8'd0, control_word[19:16]} + 13'd1) * {5'd0, cfg.fixed_div};

            byp2_reg   <= byp1_reg;
            neg2_reg   <= neg1_reg;
            ref2_reg   <= ref1_reg;
            term2_reg  <= pf_s[68:32];
            intg2_reg  <= {4'd0, ri1_reg} * {39'd0, sdiv1_reg};
            dvs2_reg   <= dvs_next;
            fault2_reg <= !down1_reg && (dvs_next == '0);
            kill2_reg  <= down1_reg || (dvs_next == '0);
            if (down1_reg)
                mode2_reg <= porc_pkg::MODE_OFF;
            else if (byp1_reg)
                mode2_reg <= porc_pkg::MODE_BYPASS;
            else if (frac1_reg)
                mode2_reg <= porc_pkg::MODE_FRAC;
            else
                mode2_reg <= porc_pkg::MODE_INT;

            if (byp2_reg)
                dvd3_reg <= {12'd0, ref2_reg};
            else if (neg2_reg)
                dvd3_reg <= intg2_reg - {7'd0, term2_reg};
            else
                dvd3_reg <= intg2_reg + {7'd0, term2_reg};
            dvs3_reg   <= dvs2_reg;
            kill3_reg  <= kill2_reg;
            fault3_reg <= fault2_reg;
            mode3_reg  <= mode2_reg;
        end
    end

    always_comb
    begin
        head.valid = v3_reg;
        head.mode  = mode3_reg;
        head.fault = fault3_reg;
        head.kill  = kill3_reg;
        head.rem   = '0;
        head.sh    = dvd3_reg;
        head.dvs   = dvs3_reg;
    end

endmodule

>>> rtl/porc_cell.sv
module porc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  porc_pkg::cell_t prev,
    output porc_pkg::cell_t cur
);

    porc_pkg::cell_t           cur_reg;
    logic [porc_pkg::DVS_W:0]  trial;
    logic [porc_pkg::DVS_W:0]  diff;
    logic                      take;

    always_comb
    begin
        trial = {prev.rem, prev.sh[porc_pkg::RATE_W-1]};
        diff  = trial - {1'b0, prev.dvs};
        take  = trial >= {1'b0, prev.dvs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (en)
        begin
            cur_reg.valid <= prev.valid;
            cur_reg.mode  <= prev.mode;
            cur_reg.fault <= prev.fault;
            cur_reg.kill  <= prev.kill;
            cur_reg.dvs   <= prev.dvs;
            cur_reg.rem   <= take ? diff[porc_pkg::DVS_W-1:0] : trial[porc_pkg::DVS_W-1:0];
            cur_reg.sh    <= {prev.sh[porc_pkg::RATE_W-2:0], take};
        end
    end

    assign cur = cur_reg;

endmodule

>>> rtl/pll_output_rate_calculator_core.sv
// PLL output rate calculator. Each item on the slave stream carries the PLL
// control, fraction and scaler words and the reference rate; one result item
// per input gives the output rate, run mode and a divider fault flag. One item
// is accepted per cycle while the input is not stalled; each item passes
// through three front stages (scaler decode and products, sdiv scaling and
// divisor, dividend combine) followed by a row of 44 restoring-divide cells,
// one quotient bit per cell, and an output register. A two-entry output
// register/skid pair decouples the result side; the input stalls only once
// both are full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
`include "pll_output_rate_calculator_core_macros.svh"
module pll_output_rate_calculator_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // control_word, fraction_word, pre_scaler_word, post_scaler_word, reference_rate
    input  logic [111:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // output_rate, run_mode, divider_fault, zero pad
    output logic [47:0]   m_tdata
);

    porc_pkg::cfg_t  cfg_reg;
    porc_pkg::cell_t chain [porc_pkg::NUM_CELLS+1];
    logic            en;
    logic            ov_reg, sv_reg;
    logic [46:0]     od_reg, sd_reg;
    logic [46:0]     last_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.has_pre    <= 1'b0;
            cfg_reg.has_post   <= 1'b0;
            cfg_reg.pre_coded  <= 1'b0;
            cfg_reg.post_coded <= 1'b0;
            cfg_reg.signed_fr  <= 1'b0;
            cfg_reg.fixed_div  <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                porc_pkg::REG_HAS_PRE:    cfg_reg.has_pre    <= cfg_data[0];
                porc_pkg::REG_HAS_POST:   cfg_reg.has_post   <= cfg_data[0];
                porc_pkg::REG_PRE_CODED:  cfg_reg.pre_coded  <= cfg_data[0];
                porc_pkg::REG_POST_CODED: cfg_reg.post_coded <= cfg_data[0];
                porc_pkg::REG_SIGNED_FR:  cfg_reg.signed_fr  <= cfg_data[0];
                porc_pkg::REG_FIXED_DIV:  cfg_reg.fixed_div  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !sv_reg;
    assign s_tready = en;

    porc_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (s_tvalid),
        .control_word     (s_tdata[31:0]),
        .fraction_word    (s_tdata[63:32]),
        .pre_scaler_word  (s_tdata[71:64]),
        .post_scaler_word (s_tdata[79:72]),
        .reference_rate   (s_tdata[111:80]),
        .cfg              (cfg_reg),
        .head             (chain[0])
    );

    for (genvar i = 0; i < porc_pkg::NUM_CELLS; i++)
    begin : g_cell
        porc_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[i]),
            .cur   (chain[i+1])
        );
    end

    assign last_d = {chain[porc_pkg::NUM_CELLS].fault, chain[porc_pkg::NUM_CELLS].mode,
                     chain[porc_pkg::NUM_CELLS].kill ? {porc_pkg::RATE_W{1'b0}}
                                                     : chain[porc_pkg::NUM_CELLS].sh};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!ov_reg || m_tready)
        begin
            if (sv_reg)
            begin
                ov_reg <= 1'b1;
                sv_reg <= 1'b0;
            end
            else
                ov_reg <= chain[porc_pkg::NUM_CELLS].valid;
        end
        else if (chain[porc_pkg::NUM_CELLS].valid && en)
            sv_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || m_tready)
            od_reg <= sv_reg ? sd_reg : last_d;
        else if (en)
            sd_reg <= last_d;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, od_reg};

    `PORC_ASSERT_IMPL(a_skid_has_out, clk, rst_n, sv_reg, ov_reg)
    `PORC_ASSERT_NEXT(a_skid_drains, clk, rst_n, sv_reg && m_tready, !sv_reg)
    `PORC_ASSERT_IMPL(a_fault_zero, clk, rst_n, m_tvalid && m_tdata[46], m_tdata[43:0] == '0)
    `PORC_ASSERT_NEVER(a_off_no_fault, clk, rst_n,
        m_tvalid && m_tdata[45:44] == porc_pkg::MODE_OFF && m_tdata[46])

endmodule
